// ===== design/lwt_pkg.sv =====
package lwt_pkg;

   localparam int BUFFER_BYTES = 4096;
   localparam int POS_W        = $clog2(BUFFER_BYTES + 1);

   localparam int START_W  = 12;
   localparam int LENGTH_W = 13;
   localparam int LINE_W   = 12;
   localparam int WORD_W   = 8;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;

   localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
   localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(BUFFER_BYTES);
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(BUFFER_BYTES - 1);

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic [START_W-1:0]  word_start;
      logic [LENGTH_W-1:0] word_length;
      logic [LINE_W-1:0]   line_index;
      logic [WORD_W-1:0]   word_index;
      logic                ends_line;
      logic                overflowed;
   } result_type;

endpackage

// ===== design/lwt_core.sv =====
module lwt_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  logic                    item_kind,
   input  logic [7:0]              item_byte,
   output logic                    result_valid,
   output lwt_pkg::result_type     result
);

   logic [lwt_pkg::POS_W-1:0]  position_ff, position_in;
   logic [lwt_pkg::POS_W-1:0]  word_start_ff, word_start_in;
   logic                       line_has_bytes_ff, line_has_bytes_in;
   logic                       escape_ff, escape_in;
   logic                       quotes_ff, quotes_in;
   logic [lwt_pkg::LINE_W-1:0] line_count_ff, line_count_in;
   logic [lwt_pkg::WORD_W-1:0] word_count_ff, word_count_in;
   logic                       overflow_ff, overflow_in;

   logic                       at_limit;
   logic [lwt_pkg::POS_W-1:0]  cur;
   logic [lwt_pkg::POS_W:0]    cur_plus;
   logic [lwt_pkg::POS_W-1:0]  next_start;
   logic                       is_break;
   logic                       has_word;
   logic [lwt_pkg::POS_W-1:0]  emit_start;
   logic [lwt_pkg::POS_W-1:0]  emit_length;
   logic [lwt_pkg::POS_W-1:0]  clamped_start;
   logic                       emit;
   logic                       emit_ends;

   assign at_limit   = (position_ff >= lwt_pkg::POS_LIMIT);
   assign cur        = at_limit ? lwt_pkg::POS_LIMIT : position_ff;
   assign cur_plus   = {1'b0, cur} + (lwt_pkg::POS_W + 1)'(1);
   assign next_start = (cur_plus > (lwt_pkg::POS_W + 1)'(lwt_pkg::BUFFER_BYTES))
                       ? lwt_pkg::POS_LIMIT : cur_plus[lwt_pkg::POS_W-1:0];
   assign is_break   = (item_kind == lwt_pkg::KIND_END) || (item_byte == lwt_pkg::CH_CR)
                       || (item_byte == lwt_pkg::CH_LF) || (item_byte == lwt_pkg::CH_NUL);
   assign has_word   = (cur > word_start_ff);

   always_comb begin
      position_in       = position_ff;
      word_start_in     = word_start_ff;
      line_has_bytes_in = line_has_bytes_ff;
      escape_in         = escape_ff;
      quotes_in         = quotes_ff;
      line_count_in     = line_count_ff;
      word_count_in     = word_count_ff;
      overflow_in       = overflow_ff;
      emit              = 1'b0;
      emit_ends         = 1'b0;
      emit_start        = has_word ? word_start_ff : cur;
      emit_length       = has_word ? (cur - word_start_ff) : '0;

      if (item_kind == lwt_pkg::KIND_DATA) begin
         if (at_limit) begin
            overflow_in = 1'b1;
         end else begin
            position_in = position_ff + lwt_pkg::POS_W'(1);
         end
      end

      if (is_break) begin
         emit      = line_has_bytes_ff;
         emit_ends = 1'b1;
         if (line_has_bytes_ff && (line_count_ff != lwt_pkg::LINE_MAX)) begin
            line_count_in = line_count_ff + lwt_pkg::LINE_W'(1);
         end
         word_count_in     = '0;
         escape_in         = 1'b0;
         quotes_in         = 1'b0;
         line_has_bytes_in = 1'b0;
         word_start_in     = next_start;
         if (item_kind == lwt_pkg::KIND_END) begin
            position_in   = '0;
            word_start_in = '0;
            line_count_in = '0;
            overflow_in   = 1'b0;
         end
      end else begin
         line_has_bytes_in = 1'b1;
         priority if (item_byte == lwt_pkg::CH_BSL && !escape_ff) begin
            escape_in = 1'b1;
         end else if (item_byte == lwt_pkg::CH_QUOTE && !escape_ff) begin
            quotes_in = !quotes_ff;
         end else if (item_byte == lwt_pkg::CH_SPACE && !quotes_ff && !escape_ff) begin
            emit = has_word;
            if (has_word && (word_count_ff != lwt_pkg::WORD_MAX)) begin
               word_count_in = word_count_ff + lwt_pkg::WORD_W'(1);
            end
            word_start_in = next_start;
         end else if (escape_ff) begin
            escape_in = 1'b0;
         end
      end
   end

   assign clamped_start = (emit_start > lwt_pkg::POS_LAST) ? lwt_pkg::POS_LAST : emit_start;

   assign result_valid       = item_valid && emit;
   assign result.word_start  = clamped_start[lwt_pkg::START_W-1:0];
   assign result.word_length = lwt_pkg::LENGTH_W'(emit_length);
   assign result.line_index  = line_count_ff;
   assign result.word_index  = word_count_ff;
   assign result.ends_line   = emit_ends;
   assign result.overflowed  = (item_kind == lwt_pkg::KIND_DATA) ? (overflow_ff || at_limit)
                                                                 : overflow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff       <= '0;
         word_start_ff     <= '0;
         line_has_bytes_ff <= 1'b0;
         escape_ff         <= 1'b0;
         quotes_ff         <= 1'b0;
         line_count_ff     <= '0;
         word_count_ff     <= '0;
         overflow_ff       <= 1'b0;
      end else if (item_valid) begin
         position_ff       <= position_in;
         word_start_ff     <= word_start_in;
         line_has_bytes_ff <= line_has_bytes_in;
         escape_ff         <= escape_in;
         quotes_ff         <= quotes_in;
         line_count_ff     <= line_count_in;
         word_count_ff     <= word_count_in;
         overflow_ff       <= overflow_in;
      end
   end

endmodule

// ===== design/lwt_skid.sv =====
module lwt_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  lwt_pkg::result_type push_data,
   output logic                push_ready,
   output logic                out_valid,
   output lwt_pkg::result_type out_data,
   input  logic                out_ready
);

   logic                out_valid_ff, out_valid_in;
   lwt_pkg::result_type out_data_ff, out_data_in;
   logic                skid_valid_ff, skid_valid_in;
   lwt_pkg::result_type skid_data_ff, skid_data_in;
   logic                out_free;

   assign push_ready = !skid_valid_ff;
   assign out_free   = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push_valid;
            out_data_in  = push_data;
         end
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== design/line_word_tokenizer.sv =====
// Splits a byte stream into lines (CR, LF or NUL) and words (spaces), honoring
// backslash escapes and double quotes, and reports one transfer per word or
// bare line end. A buffer is closed by a transfer with req_tuser = 1, which
// also clears all tokenizer state. One byte is taken every clock while
// req_tready is high; results are registered in the output buffer before they
// reach rsp_tdata. A two-entry output buffer keeps req_tready high while one
// result waits on rsp_tready.
module line_word_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tuser,   // [0] kind (1 = end of buffer)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [11:0] word_start, [24:12] word_length,
                                    // [36:25] line_index, [44:37] word_index, rest 0
   output logic        rsp_tlast,   // ends_line
   output logic        rsp_tuser    // [0] overflowed
);

   logic                req_accept;
   logic                push_valid;
   logic                push_ready;
   lwt_pkg::result_type push_data;
   lwt_pkg::result_type rsp_data;

   assign req_tready = push_ready;
   assign req_accept = req_tvalid && push_ready;

   lwt_core u_core (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (req_accept),
      .item_kind    (req_tuser),
      .item_byte    (req_tdata),
      .result_valid (push_valid),
      .result       (push_data)
   );

   lwt_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .out_valid  (rsp_tvalid),
      .out_data   (rsp_data),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {3'b000, rsp_data.word_index, rsp_data.line_index,
                       rsp_data.word_length, rsp_data.word_start};
   assign rsp_tlast = rsp_data.ends_line;
   assign rsp_tuser = rsp_data.overflowed;

endmodule
